// ===== rtl/plt_pkg.sv =====
`timescale 1ns / 1ps

package plt_pkg;

    // pin geometry and user table size
    localparam int PIN_LENGTH = 4;
    localparam int USER_COUNT = 4;
    localparam int CODE_SLOTS = 4;
    localparam int CNT_W      = $clog2(PIN_LENGTH + 1);
    localparam int PACK_W     = PIN_LENGTH * 8;
    localparam int CMP_W      = (PACK_W > 32) ? PACK_W : 32;

    // special keys
    localparam logic [7:0] KEY_NONE = 8'd0;
    localparam logic [7:0] KEY_STAR = 8'd42;
    localparam logic [7:0] KEY_HASH = 8'd35;
    localparam logic [2:0] STAR_LOGOUT = 3'd3;

    // action codes
    localparam logic ACT_KEY    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // event codes
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_DIGIT   = 4'd1;
    localparam logic [3:0] EV_CLEARED = 4'd2;
    localparam logic [3:0] EV_SHORT   = 4'd3;
    localparam logic [3:0] EV_WRONG   = 4'd4;
    localparam logic [3:0] EV_LOGIN   = 4'd5;
    localparam logic [3:0] EV_LOGOUT  = 4'd6;
    localparam logic [3:0] EV_LEFT    = 4'd7;
    localparam logic [3:0] EV_RIGHT   = 4'd8;
    localparam logic [3:0] EV_FRONT   = 4'd9;
    localparam logic [3:0] EV_BACK    = 4'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_CODE0   = 3'd0;
    localparam logic [2:0] CFG_CODE1   = 3'd1;
    localparam logic [2:0] CFG_CODE2   = 3'd2;
    localparam logic [2:0] CFG_CODE3   = 3'd3;
    localparam logic [2:0] CFG_MARGIN  = 3'd4;
    localparam logic [2:0] CFG_HOLDOFF = 3'd5;

    // configuration reset values
    localparam logic [31:0] RST_CODE0   = 32'd909719097;
    localparam logic [31:0] RST_CODE1   = 32'd825307441;
    localparam logic [31:0] RST_CODE2   = 32'd808727088;
    localparam logic [31:0] RST_CODE3   = 32'd909588023;
    localparam logic [14:0] RST_MARGIN  = 15'd1920;
    localparam logic [31:0] RST_HOLDOFF = 32'd3000;

    typedef struct packed {
        logic              action;
        logic [7:0]        key_char;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic [31:0]       time_ms;
        logic              link_up;
    } t_in_word;

    typedef struct packed {
        logic [3:0] event_res;
        logic [1:0] user_index;
        logic       logged_in;
        logic       notify;
    } t_out_word;

    typedef struct packed {
        logic [CODE_SLOTS-1:0][31:0] code;
        logic [14:0]                 margin;
        logic [31:0]                 holdoff;
    } t_cfg;

    typedef struct packed {
        logic [PIN_LENGTH-1:0][7:0] pin_buf;
        logic [CNT_W-1:0]           pin_cnt;
        logic                       sess_valid;
        logic [1:0]                 sess_user;
        logic [1:0]                 star_run;
        logic [31:0]                last_ms;
    } t_state;

endpackage

// ===== rtl/plt_cfg_regs.sv =====
`timescale 1ns / 1ps

module plt_cfg_regs import plt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CODE0, CFG_CODE1, CFG_CODE2, CFG_CODE3: begin
                    n_cfg.code[i_cfg_idx[1:0]] = i_cfg_data;
                end
                CFG_MARGIN:  n_cfg.margin  = i_cfg_data[14:0];
                CFG_HOLDOFF: n_cfg.holdoff = i_cfg_data;
                default: ; // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code[0] <= RST_CODE0;
            r_cfg.code[1] <= RST_CODE1;
            r_cfg.code[2] <= RST_CODE2;
            r_cfg.code[3] <= RST_CODE3;
            r_cfg.margin  <= RST_MARGIN;
            r_cfg.holdoff <= RST_HOLDOFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/plt_step.sv =====
`timescale 1ns / 1ps

module plt_step import plt_pkg::*; (
    input  t_in_word  i_word,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_word o_word
);

    logic [PACK_W-1:0] packed_pin;
    logic              hit;
    logic [1:0]        hit_idx;
    logic [2:0]        star_inc;
    logic [16:0]       mag_x;
    logic [16:0]       mag_y;
    logic [3:0]        dir;
    logic [31:0]       elapsed;
    logic              pin_full;
    t_state            st;
    logic [3:0]        ev;
    logic              nt;

    // buffer packed with the first key in the top byte
    always_comb begin
        for (int i = 0; i < PIN_LENGTH; i++) begin
            packed_pin[(PIN_LENGTH-1-i)*8 +: 8] = i_state.pin_buf[i];
        end
    end

    // lowest matching user wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = 2'd0;
        for (int i = USER_COUNT - 1; i >= 0; i--) begin
            if (CMP_W'(packed_pin) == CMP_W'(i_cfg.code[i])) begin
                hit     = 1'b1;
                hit_idx = 2'(i);
            end
        end
    end

    assign pin_full = (i_state.pin_cnt >= CNT_W'(PIN_LENGTH));
    assign star_inc = {1'b0, i_state.star_run} + 3'd1;

    // magnitudes, 17 bits to hold the most negative value
    assign mag_x = i_word.accel_x[15] ? (17'h10000 - {1'b0, i_word.accel_x})
                                      : {1'b0, i_word.accel_x};
    assign mag_y = i_word.accel_y[15] ? (17'h10000 - {1'b0, i_word.accel_y})
                                      : {1'b0, i_word.accel_y};
    assign elapsed = i_word.time_ms - i_state.last_ms;

    always_comb begin
        if (mag_x > mag_y + {2'b00, i_cfg.margin}) begin
            dir = i_word.accel_x[15] ? EV_LEFT : EV_RIGHT;
        end else if (mag_y > mag_x + {2'b00, i_cfg.margin}) begin
            dir = i_word.accel_y[15] ? EV_BACK : EV_FRONT;
        end else begin
            dir = EV_NONE;
        end
    end

    always_comb begin
        st = i_state;
        ev = EV_NONE;
        nt = 1'b0;
        if (i_word.action == ACT_KEY) begin
            if (i_word.key_char == KEY_NONE) begin
                ev = EV_NONE;
            end else if (i_word.key_char == KEY_STAR) begin
                st.pin_buf = '0;
                st.pin_cnt = '0;
                if (star_inc >= STAR_LOGOUT) begin
                    st.sess_valid = 1'b0;
                    st.sess_user  = 2'd0;
                    st.star_run   = 2'd0;
                    ev            = EV_LOGOUT;
                    nt            = i_word.link_up;
                end else begin
                    st.star_run = star_inc[1:0];
                    ev          = EV_CLEARED;
                end
            end else begin
                st.star_run = 2'd0;
                if (i_word.key_char == KEY_HASH) begin
                    if (!i_state.sess_valid) begin
                        if (!pin_full) begin
                            ev = EV_SHORT;
                        end else if (hit) begin
                            st.sess_valid = 1'b1;
                            st.sess_user  = hit_idx;
                            ev            = EV_LOGIN;
                            nt            = i_word.link_up;
                        end else begin
                            st.pin_buf = '0;
                            st.pin_cnt = '0;
                            ev         = EV_WRONG;
                        end
                    end
                end else if (!i_state.sess_valid && !pin_full) begin
                    for (int i = 0; i < PIN_LENGTH; i++) begin
                        if (i_state.pin_cnt == CNT_W'(i)) begin
                            st.pin_buf[i] = i_word.key_char;
                        end
                    end
                    st.pin_cnt = i_state.pin_cnt + CNT_W'(1);
                    ev         = EV_DIGIT;
                end
            end
        end else if (i_state.sess_valid && i_word.link_up) begin
            if (dir != EV_NONE && elapsed > i_cfg.holdoff) begin
                ev         = dir;
                nt         = 1'b1;
                st.last_ms = i_word.time_ms;
            end
        end
    end

    assign o_state           = st;
    assign o_word.event_res  = ev;
    assign o_word.user_index = st.sess_valid ? st.sess_user : 2'd0;
    assign o_word.logged_in  = st.sess_valid;
    assign o_word.notify     = nt;

endmodule

// ===== rtl/pin_login_tilt_direction_reporter_top.sv =====
`timescale 1ns / 1ps
// path: a word is held in the input register, decoded, then held in the result register
// throughput: one word per cycle unless stalled; single input register and result register
// the result register frees itself in the same cycle it is taken, so no bubbles under flow
// reset: synchronous active low; pin buffer, session, star count, report time and
// configuration return to their defaults, both stages empty

module pin_login_tilt_direction_reporter_top import plt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg      cfg;

    // input stage
    logic      r_in_valid;
    t_in_word  r_in;

    // persistent session state
    t_state    r_state;
    t_state    n_state;

    // result stage
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;

    logic      advance;
    logic      take_in;

    // the input word moves on whenever the result register is empty or being taken
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in    = i_in_valid && o_in_ready;

    plt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // all decoding for one word, between the input and result registers
    plt_step u_step (
        .i_word  (r_in),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_word  (n_out)
    );

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // session state commits once per word as it leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/plt_checker.sv =====
`timescale 1ns / 1ps

module plt_checker import plt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word dropped or changed while stalled");

    // no user shown without a session
    a_user_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.logged_in |-> o_out.user_index == 2'd0)
        else $error("user index set while logged out");

    // notify only for login, logout or direction
    a_notify_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.notify |->
            o_out.event_res == EV_LOGIN || o_out.event_res == EV_LOGOUT ||
            o_out.event_res == EV_LEFT || o_out.event_res == EV_RIGHT ||
            o_out.event_res == EV_FRONT || o_out.event_res == EV_BACK)
        else $error("notify on a local event");

    // session flag agrees with the event that changed it
    a_login_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.event_res == EV_LOGIN || o_out.event_res == EV_LEFT ||
            o_out.event_res == EV_RIGHT || o_out.event_res == EV_FRONT ||
            o_out.event_res == EV_BACK) |-> o_out.logged_in)
        else $error("login or direction event without a session");

    a_logout_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.event_res == EV_LOGOUT || o_out.event_res == EV_DIGIT ||
            o_out.event_res == EV_SHORT || o_out.event_res == EV_WRONG) |->
            !o_out.logged_in && o_out.notify == 1'b0 || o_out.event_res == EV_LOGOUT)
        else $error("pin event while logged in");

endmodule

bind pin_login_tilt_direction_reporter_top plt_checker u_plt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== verif/pin_login_tilt_direction_reporter_top_test.sv =====
`timescale 1ns / 1ps

module pin_login_tilt_direction_reporter_top_test;
    import plt_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT  = 600000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 6;        // idle wait after the last report is back
    localparam int REPORT_LIMIT = 200;      // mismatch lines printed at most

    // block ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = CFG_CODE0;
    logic [31:0] cfg_data  = '0;

    // words waiting to be sent and reports waiting to come back
    t_in_word    keypad_tilt_q [$];
    t_out_word   reports_due_q [$];
    int          queued_cnt = 0;
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;

    // local copy of the lock: configuration
    logic [31:0] code_tab [USER_COUNT];
    logic [14:0] margin_cfg;
    logic [31:0] holdoff_cfg;

    // local copy of the lock: session state
    logic [7:0]  pin_chars [PIN_LENGTH];
    int          pin_fill;
    logic        session_on;
    logic [1:0]  session_idx;
    int          star_streak;
    logic [31:0] last_tilt_ms;

    // timestamp the stimulus carries forward between samples
    logic [31:0] stamp_ms;

    // sender burst shaping and receiver stall pattern
    int          burst_left = 8;
    int          gap_left   = 0;
    logic [8:0]  stall_tick = '0;

    pin_login_tilt_direction_reporter_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ---------------------------------------------------------------
    // lock predictor
    // ---------------------------------------------------------------

    function automatic void clear_pin();
        foreach (pin_chars[i]) pin_chars[i] = 8'h00;
        pin_fill = 0;
    endfunction

    // one word in, the report it must cause out; session state advances
    function automatic t_out_word predict_report(t_in_word w);
        t_out_word        r;
        logic [3:0]       ev;
        logic             ntf;
        logic [17:0]      mag_x;
        logic [17:0]      mag_y;
        logic [3:0]       tilt;
        logic [31:0]      elapsed;
        logic [CMP_W-1:0] packed_pin;
        int               hit;
        ev  = EV_NONE;
        ntf = 1'b0;
        if (w.action == ACT_KEY) begin
            if (w.key_char == KEY_NONE) begin
                ev = EV_NONE;
            end else if (w.key_char == KEY_STAR) begin
                // every star wipes the buffer, the third in a row logs out
                star_streak++;
                clear_pin();
                if (star_streak >= STAR_LOGOUT) begin
                    session_on  = 1'b0;
                    session_idx = 2'd0;
                    star_streak = 0;
                    ev          = EV_LOGOUT;
                    ntf         = w.link_up;
                end else begin
                    ev = EV_CLEARED;
                end
            end else begin
                star_streak = 0;
                if (w.key_char == KEY_HASH) begin
                    if (!session_on) begin
                        if (pin_fill < PIN_LENGTH) begin
                            ev = EV_SHORT;
                        end else begin
                            // first char lands in the top byte, lowest user wins
                            packed_pin = '0;
                            for (int i = 0; i < PIN_LENGTH; i++)
                                packed_pin = {packed_pin[CMP_W-9:0], pin_chars[i]};
                            hit = -1;
                            for (int u = USER_COUNT - 1; u >= 0; u--)
                                if (packed_pin == code_tab[u]) hit = u;
                            if (hit >= 0) begin
                                session_on  = 1'b1;
                                session_idx = hit[1:0];
                                ev          = EV_LOGIN;
                                ntf         = w.link_up;
                            end else begin
                                clear_pin();
                                ev = EV_WRONG;
                            end
                        end
                    end
                end else if (!session_on && pin_fill < PIN_LENGTH) begin
                    pin_chars[pin_fill] = w.key_char;
                    pin_fill++;
                    ev = EV_DIGIT;
                end
            end
        end else if (session_on && w.link_up) begin
            // two's complement magnitudes, -32768 gives 32768
            mag_x = w.accel_x[15] ? 18'h10000 - {2'b00, w.accel_x} : {2'b00, w.accel_x};
            mag_y = w.accel_y[15] ? 18'h10000 - {2'b00, w.accel_y} : {2'b00, w.accel_y};
            tilt  = EV_NONE;
            if (mag_x > mag_y + margin_cfg)
                tilt = w.accel_x[15] ? EV_LEFT : EV_RIGHT;
            else if (mag_y > mag_x + margin_cfg)
                tilt = w.accel_y[15] ? EV_BACK : EV_FRONT;
            // holdoff measured with wrapping 32-bit difference
            elapsed = w.time_ms - last_tilt_ms;
            if (tilt != EV_NONE && elapsed > holdoff_cfg) begin
                ev           = tilt;
                ntf          = 1'b1;
                last_tilt_ms = w.time_ms;
            end
        end
        r.event_res  = ev;
        r.user_index = session_on ? session_idx : 2'd0;
        r.logged_in  = session_on;
        r.notify     = ntf;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------

    function automatic t_in_word random_word();
        t_in_word w;
        w.action   = 1'($urandom_range(0, 1));
        w.key_char = 8'($urandom_range(0, 255));
        w.accel_x  = 16'($urandom());
        w.accel_y  = 16'($urandom());
        w.time_ms  = $urandom();
        w.link_up  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic void push_word(t_in_word w);
        keypad_tilt_q.push_back(w);
        queued_cnt++;
    endfunction

    // key word; sample fields stay random since the block must ignore them
    function automatic void push_key(logic [7:0] key, logic link);
        t_in_word w;
        w          = random_word();
        w.action   = ACT_KEY;
        w.key_char = key;
        w.link_up  = link;
        push_word(w);
    endfunction

    function automatic void push_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                        logic [31:0] stamp, logic link);
        t_in_word w;
        w         = random_word();
        w.action  = ACT_SAMPLE;
        w.accel_x = ax;
        w.accel_y = ay;
        w.time_ms = stamp;
        w.link_up = link;
        push_word(w);
    endfunction

    function automatic void push_text(string s, logic link);
        foreach (s[i]) push_key(s[i], link);
    endfunction

    function automatic logic link_mostly_up();
        return $urandom_range(0, 9) != 0;
    endfunction

    // mostly decimal digits, otherwise any enterable nonzero key
    function automatic logic [7:0] pick_pin_char();
        logic [7:0] c;
        if ($urandom_range(0, 4) != 0) return "0" + 8'($urandom_range(0, 9));
        do c = 8'($urandom_range(1, 255));
        while (c == KEY_HASH || c == KEY_STAR);
        return c;
    endfunction

    function automatic logic [31:0] pick_code();
        return {pick_pin_char(), pick_pin_char(), pick_pin_char(), pick_pin_char()};
    endfunction

    function automatic logic signed [15:0] axis_value(int mag);
        if (mag >= 32768) return 16'sh8000;
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    endfunction

    // sample near the margin and holdoff edges, time moving forward
    function automatic void push_tilt(logic link);
        int lo;
        int hi;
        case ($urandom_range(0, 3))
            0:       stamp_ms += $urandom_range(0, 40);
            1:       stamp_ms += holdoff_cfg + $urandom_range(0, 2) - 1;
            2:       stamp_ms += $urandom_range(0, 8000);
            default: stamp_ms += $urandom();
        endcase
        lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32768);
        case ($urandom_range(0, 2))
            0:       hi = lo + margin_cfg;
            1:       hi = lo + margin_cfg + 1;
            default: hi = lo + $urandom_range(0, 32768);
        endcase
        if (hi > 32768) hi = 32768;
        if ($urandom_range(0, 4) == 0)
            push_sample(16'($urandom()), 16'($urandom()), stamp_ms, link);
        else if ($urandom_range(0, 1) != 0)
            push_sample(axis_value(hi), axis_value(lo), stamp_ms, link);
        else
            push_sample(axis_value(lo), axis_value(hi), stamp_ms, link);
    endfunction

    // one stretch of user behavior: a login session, a pin attempt, a star run or random words
    function automatic void push_episode();
        int   u;
        int   n;
        int   pick;
        logic link;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // correct code, maybe one extra char, then tilts and stray keys
                u    = $urandom_range(0, USER_COUNT - 1);
                link = link_mostly_up();
                for (int i = 0; i < PIN_LENGTH; i++)
                    push_key(code_tab[u][8 * (PIN_LENGTH - 1 - i) +: 8], link);
                if ($urandom_range(0, 4) == 0) push_key(pick_pin_char(), link);
                push_key(KEY_HASH, link_mostly_up());
                n = $urandom_range(2, 14);
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)       push_tilt(link_mostly_up());
                    else if (pick == 7) push_key(pick_pin_char(), link_mostly_up());
                    else if (pick == 8) push_key(KEY_HASH, link_mostly_up());
                    else                push_key(KEY_STAR, link_mostly_up());
                end
                // logout run, sometimes broken by another key
                for (int i = 0; i < 3; i++) begin
                    if ($urandom_range(0, 5) == 0) push_key(pick_pin_char(), 1'b1);
                    push_key(KEY_STAR, link_mostly_up());
                end
            end
            4, 5: begin
                n = $urandom_range(PIN_LENGTH, PIN_LENGTH + 1);
                repeat (n) push_key(pick_pin_char(), link_mostly_up());
                push_key(KEY_HASH, link_mostly_up());
            end
            6: begin
                n = $urandom_range(0, PIN_LENGTH - 1);
                repeat (n) push_key(pick_pin_char(), link_mostly_up());
                push_key(KEY_HASH, link_mostly_up());
            end
            7: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    push_key(KEY_STAR, link_mostly_up());
                    if ($urandom_range(0, 2) == 0) push_key(pick_pin_char(), 1'b1);
                end
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) push_word(random_word());
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // configuration and phase control
    // ---------------------------------------------------------------

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CODE0:   code_tab[0] = data;
            CFG_CODE1:   code_tab[1] = data;
            CFG_CODE2:   code_tab[2] = data;
            CFG_CODE3:   code_tab[3] = data;
            CFG_MARGIN:  margin_cfg  = data[14:0];
            CFG_HOLDOFF: holdoff_cfg = data;
            default: ;
        endcase
    endtask

    // rewrite every register back to back, only while the block is idle
    task automatic set_config(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                              logic [31:0] c3, logic [31:0] margin_word,
                              logic [31:0] holdoff);
        write_cfg(CFG_CODE0, c0);
        write_cfg(CFG_CODE1, c1);
        write_cfg(CFG_CODE2, c2);
        write_cfg(CFG_CODE3, c3);
        write_cfg(CFG_MARGIN, margin_word);
        write_cfg(CFG_HOLDOFF, holdoff);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (keypad_tilt_q.size() != 0 || in_valid || reports_due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int n);
        int goal;
        goal = queued_cnt + n;
        while (queued_cnt < goal) push_episode();
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // input driver: bursts of words with random gaps
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            // current word taken (or none shown): pick what comes next
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (keypad_tilt_q.size() > 0) begin
                in_word  <= keypad_tilt_q.pop_front();
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result stall pattern: free flow, coin flip, sparse, light stalls
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[8:7])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ---------------------------------------------------------------
    // monitor: predict on every accepted word, check every result
    // ---------------------------------------------------------------

    task automatic check_field(string name, int want, int got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n) begin
            if (in_valid && in_ready)
                reports_due_q.push_back(predict_report(in_word));
            if (out_valid && out_ready) begin
                if (reports_due_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none actual %h",
                                 $time, out_word);
                end else begin
                    want = reports_due_q.pop_front();
                    check_field("event_res", want.event_res, out_word.event_res);
                    check_field("user_index", want.user_index, out_word.user_index);
                    check_field("logged_in", want.logged_in, out_word.logged_in);
                    check_field("notify", want.notify, out_word.notify);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        // predictor starts from the reset defaults
        code_tab[0]  = RST_CODE0;
        code_tab[1]  = RST_CODE1;
        code_tab[2]  = RST_CODE2;
        code_tab[3]  = RST_CODE3;
        margin_cfg   = RST_MARGIN;
        holdoff_cfg  = RST_HOLDOFF;
        clear_pin();
        session_on   = 1'b0;
        session_idx  = 2'd0;
        star_streak  = 0;
        last_tilt_ms = '0;
        stamp_ms     = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at the default codes
        push_key(KEY_NONE, 1'b1);                            // no key
        push_sample(16'sd20000, 16'sd0, 32'd100, 1'b1);      // tilt while logged out
        push_key(KEY_HASH, 1'b1);                            // empty buffer
        push_text("6969", 1'b1);
        push_key("7", 1'b1);                                 // buffer full, ignored
        push_key(KEY_HASH, 1'b1);                            // login first user
        push_key(KEY_HASH, 1'b1);                            // hash while logged in
        push_sample(16'sd32767, 16'sd0, 32'd5000, 1'b0);     // link down
        push_sample(16'sd32767, 16'sd0, 32'd5000, 1'b1);     // right
        push_sample(16'sh8000, 16'sd0, 32'd6000, 1'b1);      // inside holdoff
        push_sample(16'sh8000, 16'sd0, 32'd9000, 1'b1);      // left
        push_sample(16'sd0, 16'sh8000, 32'd12000, 1'b1);     // exactly the holdoff
        push_sample(16'sd0, 16'sh8000, 32'd12001, 1'b1);     // back
        push_sample(16'sd0, 16'sd32767, 32'd15002, 1'b1);    // front
        push_sample(16'sd1920, 16'sd0, 32'd20000, 1'b1);     // exactly the margin
        push_key(KEY_STAR, 1'b1);
        push_key("5", 1'b1);                                 // breaks the star run
        push_key(KEY_STAR, 1'b1);
        push_key(KEY_STAR, 1'b1);
        push_key(KEY_STAR, 1'b0);                            // logout, link down
        push_key(KEY_STAR, 1'b1);
        push_key(KEY_STAR, 1'b1);
        push_key(KEY_STAR, 1'b1);                            // logout while logged out
        push_text("0420", 1'b0);
        push_key(KEY_HASH, 1'b0);                            // login third user, link down
        wait_drained();

        stamp_ms = 32'd20000;
        run_random(420);

        // zero margin and zero holdoff
        set_config(pick_code(), pick_code(), pick_code(), pick_code(), 32'd0, 32'd0);
        run_random(320);

        // all-ones and all-zero codes, duplicate codes, widest margin, holdoff never ends
        begin
            logic [31:0] twin;
            twin = pick_code();
            set_config(32'hFFFF_FFFF, 32'h0000_0000, twin, twin, 32'd32767, 32'hFFFF_FFFF);
        end
        stamp_ms = $urandom();
        run_random(320);

        // random codes, margin with junk above bit 14, timestamps wrapping
        set_config(pick_code(), pick_code(), pick_code(), pick_code(),
                   {17'($urandom()), 15'($urandom_range(0, 4000))},
                   32'($urandom_range(0, 5000)));
        stamp_ms = 32'hFFFF_F000;
        run_random(420);

        // default codes again with tiny margin and holdoff
        set_config(RST_CODE0, RST_CODE1, RST_CODE2, RST_CODE3, 32'd1, 32'd1);
        run_random(420);

        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== pin_login_tilt_direction_reporter_top.f =====
rtl/plt_pkg.sv
rtl/plt_cfg_regs.sv
rtl/plt_step.sv
rtl/pin_login_tilt_direction_reporter_top.sv
rtl/plt_checker.sv
verif/pin_login_tilt_direction_reporter_top_test.sv
